### design/mrsc_pkg.sv
// Shared types and codes of the memory region safety checker.
// Used by mrsc_ctrl and by the top level; depends on nothing else.
package mrsc_pkg;

	localparam logic [1:0] CLS_HEAP     = 2'd0;
	localparam logic [1:0] CLS_STACK    = 2'd1;
	localparam logic [1:0] CLS_GLOBAL   = 2'd2;
	localparam logic [1:0] CLS_RELEASED = 2'd3;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_FREED     = 2'd1;
	localparam logic [1:0] ST_NONE      = 2'd2;

	localparam logic [3:0] K_HEAP_REC    = 4'd0;
	localparam logic [3:0] K_RELEASE     = 4'd1;
	localparam logic [3:0] K_STACK_REC   = 4'd2;
	localparam logic [3:0] K_GLOBAL_REC  = 4'd3;
	localparam logic [3:0] K_CHECK       = 4'd4;
	localparam logic [3:0] K_RESIZE      = 4'd5;
	localparam logic [3:0] K_FRAME_ENTER = 4'd6;
	localparam logic [3:0] K_FRAME_EXIT  = 4'd7;
	localparam logic [3:0] K_LEAK_SCAN   = 4'd8;
	localparam logic [3:0] K_CLEAR       = 4'd9;

	localparam logic [3:0] STS_OK              = 4'd0;
	localparam logic [3:0] STS_REL_UNALLOC     = 4'd1;
	localparam logic [3:0] STS_DOUBLE_REL      = 4'd2;
	localparam logic [3:0] STS_OUT_OF_RANGE    = 4'd3;
	localparam logic [3:0] STS_RELEASED_ACCESS = 4'd4;
	localparam logic [3:0] STS_INVALID_PTR     = 4'd5;
	localparam logic [3:0] STS_RESIZE_RELEASED = 4'd6;
	localparam logic [3:0] STS_RESIZE_UNALLOC  = 4'd7;
	localparam logic [3:0] STS_LEAK            = 4'd8;
	localparam logic [3:0] STS_TABLE_FULL      = 4'd9;

	localparam logic [15:0] MARK_MAX = 16'hFFFF;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		logic [1:0]  cls;
		logic [1:0]  st;
		logic [15:0] mark;
	} region_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] address;
		logic [63:0] new_address;
		logic [63:0] size;
		logic [31:0] count;
		logic [63:0] access_length;
	} item_t;

endpackage

### design/mrsc_table.sv
// Region table storage: one synchronous memory, one write and one read port.
// Read data is registered. No package dependency.
module mrsc_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 154
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/mrsc_ctrl.sv
// Sequencer of the region checker: table scans, decision, rank repair pass, write back.
// Depends on mrsc_pkg and drives one mrsc_table instance.
module mrsc_ctrl #(
	parameter int DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mrsc_pkg::item_t item,
	input  logic            out_free,
	output logic            idle,
	output logic            done,
	output logic [3:0]      result
);
	import mrsc_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = $bits(region_t);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MUL    = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_GAP    = 7'b0010000,
		S_WRITE  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	logic mul_hi_q;
	logic [63:0] prod_lo_q;
	logic [31:0] prod_hi_q;
	logic [IW-1:0] cnt_q;
	logic iss_q;
	logic v_s1;
	logic [IW-1:0] idx_s1;
	logic [DEPTH-1:0] valid_q;
	logic [CW-1:0] live_q;

	// Lookup results per class, newest stack region, free slot, leak flag.
	logic hit_q [4];
	logic [IW-1:0] idx_q [4];
	logic [IW-1:0] rk_q [4];
	region_t ent_q [4];
	logic ns_hit_q;
	logic [IW-1:0] ns_idx_q;
	logic [IW-1:0] ns_rk_q;
	region_t ns_ent_q;
	logic fr_hit_q;
	logic [IW-1:0] fr_idx_q;
	logic halloc_q;

	// Registered decision.
	logic [3:0] sts_q;
	logic [IW-1:0] gslot_q;
	logic [IW-1:0] grank_q;
	logic wr_q;
	logic [IW-1:0] wslot_q;
	region_t went_q;
	logic [IW-1:0] wrank_q;
	logic setv_q;
	logic remove_q;

	// Memory port.
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW+EW-1:0] mem_wdata;
	logic [IW+EW-1:0] mem_rdata;
	region_t rd_ent;
	logic [IW-1:0] rd_rank;

	mrsc_table #(.DEPTH(DEPTH), .WIDTH(IW + EW)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cnt_q),
		.rdata (mem_rdata)
	);

	assign rd_ent  = mem_rdata[EW-1:0];
	assign rd_rank = mem_rdata[IW+EW-1:EW];

	logic [31:0] mul_a;
	logic [63:0] mul_p;
	assign mul_a = mul_hi_q ? item.size[63:32] : item.size[31:0];
	assign mul_p = 64'(mul_a) * 64'(item.count);

	logic rv;
	logic contains;
	logic last_s1;
	logic gap_we;
	assign rv       = valid_q[idx_s1];
	assign contains = (rd_ent.base <= item.address) &&
		((rd_ent.base == item.address) || ((item.address - rd_ent.base) < rd_ent.length));
	assign last_s1  = v_s1 && (idx_s1 == LAST);
	assign gap_we   = (state_q == S_GAP) && v_s1 && rv && (idx_s1 != gslot_q) &&
		(rd_rank > grank_q);

	always_comb begin
		mem_we    = gap_we || (state_q == S_WRITE);
		mem_waddr = gap_we ? idx_s1 : wslot_q;
		mem_wdata = gap_we ? {rd_rank - IW'(1), rd_ent} : {wrank_q, went_q};
	end

	// Decision logic.
	logic [63:0] rec_len;
	logic [1:0] rec_cls;
	logic [1:0] rec_st;
	region_t sel;
	logic sel_hit;
	logic [63:0] off;
	logic [3:0] d_status;
	logic d_gap;
	logic [IW-1:0] d_gslot;
	logic [IW-1:0] d_grank;
	logic d_wr;
	logic [IW-1:0] d_wslot;
	region_t d_went;
	logic [IW-1:0] d_wrank;
	logic d_setv;
	logic d_remove;
	logic d_clear;

	always_comb begin
		rec_len = (item.kind == K_GLOBAL_REC) ? item.size : (prod_lo_q + {prod_hi_q, 32'd0});
		case (item.kind)
			K_STACK_REC:  rec_cls = CLS_STACK;
			K_GLOBAL_REC: rec_cls = CLS_GLOBAL;
			default:      rec_cls = CLS_HEAP;
		endcase
		rec_st = (item.kind == K_HEAP_REC) ? ST_ALLOCATED : ST_NONE;
		if (hit_q[CLS_HEAP]) begin
			sel = ent_q[CLS_HEAP];
		end else if (hit_q[CLS_STACK]) begin
			sel = ent_q[CLS_STACK];
		end else begin
			sel = ent_q[CLS_GLOBAL];
		end
		sel_hit = hit_q[CLS_HEAP] || hit_q[CLS_STACK] || hit_q[CLS_GLOBAL];
		off = item.address - sel.base;

		d_status = STS_OK;
		d_gap    = 1'b0;
		d_gslot  = '0;
		d_grank  = '0;
		d_wr     = 1'b0;
		d_wslot  = '0;
		d_went   = ent_q[CLS_HEAP];
		d_wrank  = '0;
		d_setv   = 1'b0;
		d_remove = 1'b0;
		d_clear  = 1'b0;

		case (item.kind)
			K_HEAP_REC, K_STACK_REC, K_GLOBAL_REC: begin
				if (!(item.kind == K_HEAP_REC && item.address == 64'd0)) begin
					if (hit_q[rec_cls]) begin
						d_wr     = 1'b1;
						d_wslot  = idx_q[rec_cls];
						d_went   = ent_q[rec_cls];
						d_went.st = rec_st;
						if (rec_cls != CLS_HEAP) begin
							d_went.length = rec_len;
						end
						d_wrank  = rk_q[rec_cls];
					end else if (hit_q[CLS_RELEASED]) begin
						d_gap     = 1'b1;
						d_gslot   = idx_q[CLS_RELEASED];
						d_grank   = rk_q[CLS_RELEASED];
						d_wr      = 1'b1;
						d_wslot   = idx_q[CLS_RELEASED];
						d_went    = ent_q[CLS_RELEASED];
						d_went.cls = rec_cls;
						d_went.st  = rec_st;
						d_wrank   = IW'(live_q - CW'(1));
					end else if (fr_hit_q) begin
						d_wr    = 1'b1;
						d_wslot = fr_idx_q;
						d_went  = '{base: item.address, length: rec_len, cls: rec_cls,
							st: rec_st, mark: 16'd0};
						d_wrank = IW'(live_q);
						d_setv  = 1'b1;
					end else begin
						d_status = STS_TABLE_FULL;
					end
				end
			end
			K_RELEASE: begin
				if (item.address != 64'd0) begin
					if (hit_q[CLS_HEAP] && ent_q[CLS_HEAP].base == item.address) begin
						d_gap     = 1'b1;
						d_gslot   = idx_q[CLS_HEAP];
						d_grank   = rk_q[CLS_HEAP];
						d_wr      = 1'b1;
						d_wslot   = idx_q[CLS_HEAP];
						d_went    = ent_q[CLS_HEAP];
						d_went.cls = CLS_RELEASED;
						d_went.st  = ST_FREED;
						d_wrank   = IW'(live_q - CW'(1));
					end else begin
						d_status = hit_q[CLS_RELEASED] ? STS_DOUBLE_REL : STS_REL_UNALLOC;
					end
				end
			end
			K_CHECK: begin
				if (sel_hit) begin
					if (item.access_length > sel.length ||
						off > (sel.length - item.access_length)) begin
						d_status = STS_OUT_OF_RANGE;
					end else if (sel.st == ST_FREED) begin
						d_status = STS_RELEASED_ACCESS;
					end
				end else begin
					d_status = hit_q[CLS_RELEASED] ? STS_RELEASED_ACCESS : STS_INVALID_PTR;
				end
			end
			K_RESIZE: begin
				if (item.new_address != 64'd0) begin
					if (item.address == 64'd0) begin
						if (fr_hit_q) begin
							d_wr    = 1'b1;
							d_wslot = fr_idx_q;
							d_went  = '{base: item.new_address, length: item.size,
								cls: CLS_HEAP, st: ST_ALLOCATED, mark: 16'd0};
							d_wrank = IW'(live_q);
							d_setv  = 1'b1;
						end else begin
							d_status = STS_TABLE_FULL;
						end
					end else if (!hit_q[CLS_HEAP]) begin
						d_status = STS_RESIZE_UNALLOC;
					end else if (ent_q[CLS_HEAP].st == ST_FREED) begin
						d_status = STS_RESIZE_RELEASED;
					end else begin
						d_gap   = 1'b1;
						d_gslot = idx_q[CLS_HEAP];
						d_grank = rk_q[CLS_HEAP];
						d_wr    = 1'b1;
						d_wslot = idx_q[CLS_HEAP];
						d_went  = '{base: item.new_address, length: item.size,
							cls: CLS_HEAP, st: ST_ALLOCATED, mark: 16'd0};
						d_wrank = IW'(live_q - CW'(1));
					end
				end
			end
			K_FRAME_ENTER: begin
				if (ns_hit_q && ns_ent_q.mark != MARK_MAX) begin
					d_wr    = 1'b1;
					d_wslot = ns_idx_q;
					d_went  = ns_ent_q;
					d_went.mark = ns_ent_q.mark + 16'd1;
					d_wrank = ns_rk_q;
				end
			end
			K_FRAME_EXIT: begin
				if (ns_hit_q) begin
					if (ns_ent_q.mark != 16'd0) begin
						d_wr    = 1'b1;
						d_wslot = ns_idx_q;
						d_went  = ns_ent_q;
						d_went.mark = ns_ent_q.mark - 16'd1;
						d_wrank = ns_rk_q;
					end else begin
						d_gap    = 1'b1;
						d_gslot  = ns_idx_q;
						d_grank  = ns_rk_q;
						d_remove = 1'b1;
					end
				end
			end
			K_LEAK_SCAN: begin
				d_status = halloc_q ? STS_LEAK : STS_OK;
			end
			K_CLEAR: begin
				d_clear = 1'b1;
			end
			default: begin
				d_status = STS_OK;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mul_hi_q <= 1'b0;
			iss_q    <= 1'b0;
			v_s1     <= 1'b0;
			cnt_q    <= '0;
			valid_q  <= '0;
			live_q   <= '0;
		end else begin
			v_s1 <= ((state_q == S_SCAN) || (state_q == S_GAP)) && iss_q;
			if (((state_q == S_SCAN) || (state_q == S_GAP)) && iss_q) begin
				if (cnt_q == LAST) begin
					iss_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_MUL;
						mul_hi_q <= 1'b0;
					end
				end
				S_MUL: begin
					mul_hi_q <= 1'b1;
					if (mul_hi_q) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						iss_q   <= 1'b1;
					end
				end
				S_SCAN: begin
					if (last_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (d_clear) begin
						valid_q <= '0;
						live_q  <= '0;
					end
					if (d_gap) begin
						state_q <= S_GAP;
						cnt_q   <= '0;
						iss_q   <= 1'b1;
					end else if (d_wr) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_GAP: begin
					if (last_s1) begin
						if (remove_q) begin
							valid_q[gslot_q] <= 1'b0;
							live_q  <= live_q - CW'(1);
							state_q <= S_SCAN;
							cnt_q   <= '0;
							iss_q   <= 1'b1;
						end else if (wr_q) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					if (setv_q) begin
						valid_q[wslot_q] <= 1'b1;
						live_q <= live_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Products, scan results and the registered decision.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			if (mul_hi_q) begin
				prod_hi_q <= mul_p[31:0];
			end else begin
				prod_lo_q <= mul_p;
			end
		end
		if ((state_q == S_MUL && mul_hi_q) || (state_q == S_GAP && last_s1)) begin
			for (int c = 0; c < 4; c++) begin
				hit_q[c] <= 1'b0;
			end
			ns_hit_q <= 1'b0;
			fr_hit_q <= 1'b0;
			halloc_q <= 1'b0;
		end else if (state_q == S_SCAN && v_s1) begin
			for (int c = 0; c < 4; c++) begin
				if (rv && rd_ent.cls == 2'(c) && contains &&
					(!hit_q[c] || rd_rank > rk_q[c])) begin
					hit_q[c] <= 1'b1;
					idx_q[c] <= idx_s1;
					rk_q[c]  <= rd_rank;
					ent_q[c] <= rd_ent;
				end
			end
			if (rv && rd_ent.cls == CLS_STACK && (!ns_hit_q || rd_rank > ns_rk_q)) begin
				ns_hit_q <= 1'b1;
				ns_idx_q <= idx_s1;
				ns_rk_q  <= rd_rank;
				ns_ent_q <= rd_ent;
			end
			if (!rv && !fr_hit_q) begin
				fr_hit_q <= 1'b1;
				fr_idx_q <= idx_s1;
			end
			if (rv && rd_ent.cls == CLS_HEAP && rd_ent.st == ST_ALLOCATED) begin
				halloc_q <= 1'b1;
			end
		end
		if (((state_q == S_SCAN) || (state_q == S_GAP)) && iss_q) begin
			idx_s1 <= cnt_q;
		end
		if (state_q == S_DECIDE) begin
			sts_q    <= d_status;
			gslot_q  <= d_gslot;
			grank_q  <= d_grank;
			wr_q     <= d_wr;
			wslot_q  <= d_wslot;
			went_q   <= d_went;
			wrank_q  <= d_wrank;
			setv_q   <= d_setv;
			remove_q <= d_remove;
		end
	end

	assign idle   = (state_q == S_IDLE);
	assign done   = (state_q == S_DONE) && out_free;
	assign result = sts_q;

`ifndef SYNTH
	a_live_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(live_q))
		else $error("live count disagrees with the valid bits");

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_GAP || state_q == S_WRITE))
		else $error("table written outside an update phase");

	a_gap_then_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GAP && last_s1 && remove_q) |=> (state_q == S_SCAN && iss_q))
		else $error("frame exit removal did not restart the scan");

	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && d_status != STS_OK) |-> (!d_wr && !d_gap && !d_clear))
		else $error("error status with a table update");
`endif

endmodule

### design/memory_region_safety_checker_top.sv
// Top level of the memory region safety checker: input word capture, result register.
// Depends on mrsc_pkg and mrsc_ctrl (which holds the region table in mrsc_table).
//
// Usage. The input channel (in_valid / in_ready) carries one operation word:
// kind, address, new_address, size, count and access_length. The output
// channel (out_valid / out_ready) returns exactly one status word per
// operation, in order. The block works on one word at a time.
//
// Sequence. The region table sits in a single-port-read synchronous memory and
// every operation scans it one entry per cycle. A word passes through a start
// step, the 64-bit by 32-bit length product, the scan, a decision step, a rank
// repair pass when an entry is moved to newest or removed, a write step when
// an entry changes and the hand-over of the status; the next word is taken
// once the status has been handed over. A frame exit repeats scan and repair
// for every stack region it removes.
//
// Reset clears every valid bit at once, so the table is empty right after
// reset without a clearing pass. When the receiver stalls, the finished status
// waits in the output register and the next word is still accepted; a second
// finished status then waits inside the block until the register frees.
module memory_region_safety_checker_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  kind,
	input  logic [63:0] address,
	input  logic [63:0] new_address,
	input  logic [63:0] size,
	input  logic [31:0] count,
	input  logic [63:0] access_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status
);
	import mrsc_pkg::*;

	item_t item_q;
	logic out_valid_q;
	logic [3:0] status_q;
	logic idle;
	logic done;
	logic [3:0] result;
	logic start_q;
	logic out_free;

	assign in_ready = idle && !start_q;
	assign out_free = !out_valid_q || out_ready;

	// Capture the accepted word; the controller reads it for the whole operation.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= '{kind: kind, address: address, new_address: new_address,
				size: size, count: count, access_length: access_length};
		end
		if (done) begin
			status_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_valid && in_ready;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	mrsc_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.item     (item_q),
		.out_free (out_free),
		.idle     (idle),
		.done     (done),
		.result   (result)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule
